/* rtl/core/tnu_pkg.sv */
// Shared constants for the upward triangle normal block.
package tnu_pkg;

    // Default vertex coordinate width in bits.
    localparam int DEF_COORD_WIDTH = 16;

    // Default number of fraction bits of the unit normal.
    localparam int DEF_NORMAL_FRAC_BITS = 14;

    // Depth of the queue between the front and back pipelines.
    localparam int QUEUE_DEPTH = 4;

endpackage

/* rtl/core/tnu_front.sv */
// Front pipeline: edge vectors, exact cross product, magnitudes and classification.
module tnu_front
    import tnu_pkg::*;
#(
    parameter int COORD_WIDTH      = DEF_COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [9*COORD_WIDTH-1:0]              in_data,
    input  logic                                  queue_full,
    output logic                                  push,
    output logic [3*(2*COORD_WIDTH+2)+4-1:0]      push_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int EW  = CW + 1;
    localparam int PRW = 2 * EW;
    localparam int RW  = 2 * CW + 3;
    localparam int MW  = 2 * CW + 2;

    logic                 en;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [CW-1:0] crd [9];
    logic signed [EW-1:0] edge_reg [6];
    logic signed [PRW-1:0] prod_reg [6];
    logic signed [RW-1:0] r_reg [3];
    logic [MW-1:0]        u_reg [3];
    logic [2:0]           neg_reg;
    logic                 degen_reg;

    // The whole front moves while the queue has room.
    assign en       = !queue_full;
    assign in_ready = en;
    assign push     = v4_reg && en;

    // Unpack the nine coordinates, lowest field first.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            crd[i] = $signed(in_data[i*CW +: CW]);
        end
    end

    // Valid bits of the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage one: edges B-A and C-A; stage two: the six products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                edge_reg[i]     <= EW'(crd[3+i]) - EW'(crd[i]);
                edge_reg[3 + i] <= EW'(crd[6+i]) - EW'(crd[i]);
            end
            prod_reg[0] <= edge_reg[1] * edge_reg[5];
            prod_reg[1] <= edge_reg[2] * edge_reg[4];
            prod_reg[2] <= edge_reg[2] * edge_reg[3];
            prod_reg[3] <= edge_reg[0] * edge_reg[5];
            prod_reg[4] <= edge_reg[0] * edge_reg[4];
            prod_reg[5] <= edge_reg[1] * edge_reg[3];
        end
    end

    // Stage three: cross product; stage four: magnitudes, signs and flags.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= RW'(prod_reg[2*i]) - RW'(prod_reg[2*i+1]);
                u_reg[i] <= r_reg[i][RW-1] ? MW'(-r_reg[i]) : MW'(r_reg[i]);
                neg_reg[i] <= r_reg[i][RW-1];
            end
            degen_reg <= (r_reg[0] == '0) && (r_reg[1] == '0) && (r_reg[2] == '0);
        end
    end

    // Beat to the queue: degenerate, flip, y sign, x sign, |z|, |y|, |x|.
    assign push_data = {degen_reg, neg_reg[2], neg_reg[1], neg_reg[0],
                        u_reg[2], u_reg[1], u_reg[0]};

endmodule

/* rtl/core/tnu_queue.sv */
// Short first-in first-out queue between the front and back pipelines.
module tnu_queue
    import tnu_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = slot_reg[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/tnu_back.sv */
// Back pipeline: sum of squares and bit-per-stage exact rounded normalisation.
module tnu_back
    import tnu_pkg::*;
#(
    parameter int COORD_WIDTH      = DEF_COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  not_empty,
    output logic                                  pop,
    input  logic [3*(2*COORD_WIDTH+2)+4-1:0]      pop_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [NORMAL_FRAC_BITS+1:0]           nx,
    output logic [NORMAL_FRAC_BITS+1:0]           ny,
    output logic [NORMAL_FRAC_BITS:0]             nz,
    output logic                                  degenerate
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int MW = 2 * COORD_WIDTH + 2;
    localparam int SW = 2 * MW + 2;
    localparam int WW = SW + 2 * F + 5;
    localparam int QW = F + 1;
    localparam int NK = F + 2;
    localparam logic [QW:0] ONE_Q = (QW+1)'(1) << F;

    logic                 en;
    logic                 b0_v_reg, b1_v_reg, b2_v_reg, out_v_reg;
    logic [MW-1:0]        u_reg [3];
    logic [2*MW-1:0]      sq_reg [3];
    logic [2*MW-1:0]      sq2_reg [3];
    logic [SW-1:0]        sum_reg;
    logic [3:0]           f0_reg, f1_reg, f2_reg;
    logic                 v_reg [NK];
    logic [3:0]           fl_reg [NK];
    logic [SW-1:0]        s_reg [NK];
    logic signed [WW-1:0] e_reg [NK][3];
    logic signed [WW-1:0] qq_reg [NK][3];
    logic [QW-1:0]        q_reg [NK][3];
    logic [F+1:0]         nx_reg, ny_reg;
    logic [F:0]           nz_reg;
    logic                 dg_reg;

    // The back pipeline stalls as a whole when the output beat is held.
    assign en         = !out_v_reg || out_ready;
    assign pop        = not_empty && en;
    assign out_valid  = out_v_reg;
    assign nx         = nx_reg;
    assign ny         = ny_reg;
    assign nz         = nz_reg;
    assign degenerate = dg_reg;

    // Valid bits of the set-up stages and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_v_reg  <= 1'b0;
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            v_reg[0]  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b0_v_reg  <= pop;
            b1_v_reg  <= b0_v_reg;
            b2_v_reg  <= b1_v_reg;
            v_reg[0]  <= b2_v_reg;
            out_v_reg <= v_reg[NK-1];
        end
    end

    // Set-up: squares, their sum, then the remainder and the running term.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                u_reg[j]   <= pop_data[j*MW +: MW];
                sq_reg[j]  <= u_reg[j] * u_reg[j];
                sq2_reg[j] <= sq_reg[j];
                e_reg[0][j]  <= (WW'(sq2_reg[j]) << (2*F+2)) - WW'(sum_reg);
                qq_reg[0][j] <= -WW'(sum_reg);
                q_reg[0][j]  <= '0;
            end
            f0_reg    <= pop_data[3*MW +: 4];
            sum_reg   <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            f1_reg    <= f0_reg;
            f2_reg    <= f1_reg;
            fl_reg[0] <= f2_reg;
            s_reg[0]  <= sum_reg;
        end
    end

    // One stage per result bit, from the top bit down: keep the bit while
    // (2q-1)^2 * S stays within 4 * |N_i|^2 * 2^(2F).
    for (genvar k = 0; k < NK - 1; k++)
    begin : g_bit
        localparam int B = F - k;
        logic signed [WW-1:0] s_ext;

        assign s_ext = WW'(s_reg[k]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fl_reg[k+1] <= fl_reg[k];
                s_reg[k+1]  <= s_reg[k];
            end
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_comp
            logic [QW:0]          t;
            logic signed [WW-1:0] cand;
            logic                 keep;

            assign t    = {1'b0, q_reg[k][j]} | ((QW+1)'(1) << B);
            assign cand = e_reg[k][j] - (qq_reg[k][j] <<< (B+2)) - (s_ext <<< (2*B+2));
            assign keep = (t <= ONE_Q) && !cand[WW-1];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (keep)
                    begin
                        e_reg[k+1][j]  <= cand;
                        qq_reg[k+1][j] <= qq_reg[k][j] + (s_ext <<< (B+1));
                        q_reg[k+1][j]  <= t[QW-1:0];
                    end
                    else
                    begin
                        e_reg[k+1][j]  <= e_reg[k][j];
                        qq_reg[k+1][j] <= qq_reg[k][j];
                        q_reg[k+1][j]  <= q_reg[k][j];
                    end
                end
            end
        end
    end

    // Output register: signs with the upward flip, zero for a degenerate face.
    // Flag order: bit 0 x negative, bit 1 y negative, bit 2 flip, bit 3 degenerate.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dg_reg <= fl_reg[NK-1][3];
            if (fl_reg[NK-1][3])
            begin
                nx_reg <= '0;
                ny_reg <= '0;
                nz_reg <= '0;
            end
            else
            begin
                nx_reg <= (fl_reg[NK-1][0] ^ fl_reg[NK-1][2]) ?
                          (F+2)'(-{1'b0, q_reg[NK-1][0]}) : (F+2)'(q_reg[NK-1][0]);
                ny_reg <= (fl_reg[NK-1][1] ^ fl_reg[NK-1][2]) ?
                          (F+2)'(-{1'b0, q_reg[NK-1][1]}) : (F+2)'(q_reg[NK-1][1]);
                nz_reg <= q_reg[NK-1][2];
            end
        end
    end

endmodule

/* rtl/core/triangle_normal_upward.sv */
// Top level of the upward unit face normal of a triangle.
//
// Takes one triangle per beat and returns its exactly rounded unit normal in
// signed fixed point with NORMAL_FRAC_BITS fraction bits, flipped so that z is
// never negative; a zero cross product gives a zero normal and the degenerate
// flag. A new triangle is taken every clock while the queue has room. A beat
// passes through 4 front stages, the queue, 4 set-up stages, one stage per
// result bit and the output register. The front and back pipelines are
// parted by a 4-entry queue, so a held output stalls the input only once
// the queue is full.
module triangle_normal_upward
    import tnu_pkg::*;
#(
    parameter int COORD_WIDTH      = DEF_COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, then zero fill to whole bytes
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]            s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // nx, ny, nz, then zero fill to whole bytes
    output logic [((3*NORMAL_FRAC_BITS+5+7)/8)*8-1:0]     m_tdata,
    // degenerate
    output logic [0:0]                                    m_tuser
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int QD = 3 * (2 * COORD_WIDTH + 2) + 4;
    localparam int OW = ((3*F+5+7)/8)*8;

    logic          push, queue_full, pop, not_empty;
    logic [QD-1:0] push_data, pop_data;
    logic [F+1:0]  nx, ny;
    logic [F:0]    nz;
    logic          degenerate;

    tnu_front #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata[9*COORD_WIDTH-1:0]),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    tnu_queue #(
        .WIDTH (QD)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    tnu_back #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .pop        (pop),
        .pop_data   (pop_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .nx         (nx),
        .ny         (ny),
        .nz         (nz),
        .degenerate (degenerate)
    );

    // Pack the result beat, lowest field first.
    assign m_tdata = OW'({nz, ny, nx});
    assign m_tuser = degenerate;

endmodule
